// ===== rtl/twsa_pkg.sv =====
// ----------------------------------------------------------------------------
// twsa_pkg
// Shared types, widths and codes of the time-weighted statistics accumulator.
// ----------------------------------------------------------------------------
package twsa_pkg;

   localparam int DEF_TIME_BITS = 48;
   localparam int ACC_W         = 64;
   localparam int VAL_W         = 32;
   localparam int CNT_W         = 32;
   localparam int LEN_W         = 32;
   localparam int MODE_W        = 2;

   localparam logic [LEN_W-1:0] DEF_PERIOD_LEN = 32'd5000;

   // response bit layout
   localparam int RSP_MEAN_LO  = 0;
   localparam int RSP_VAR_LO   = RSP_MEAN_LO + ACC_W;
   localparam int RSP_HIGH_LO  = RSP_VAR_LO + ACC_W;
   localparam int RSP_LOW_LO   = RSP_HIGH_LO + VAL_W;
   localparam int RSP_CNT_LO   = RSP_LOW_LO + VAL_W;
   localparam int RSP_DATA_W   = RSP_CNT_LO + CNT_W;

   // iterative multiplier and divider
   localparam int MUL_DIGIT_W  = 16;
   localparam int MUL_STEPS    = ACC_W / MUL_DIGIT_W;
   localparam int MUL_CNT_W    = $clog2(MUL_STEPS);
   localparam int DIV_CNT_W    = $clog2(ACC_W);

   localparam logic [MODE_W-1:0] MODE_RESET  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SAMPLE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DECODE,
      ST_RESET,
      ST_S_ELAP,
      ST_S_COMMIT,
      ST_Q_DIV_GO,
      ST_Q_DIV_WAIT,
      ST_Q_MUL_GO,
      ST_Q_MUL_WAIT,
      ST_Q_FIRST,
      ST_Q_CHECK,
      ST_WS_GO,
      ST_WS_WAIT,
      ST_SQ_GO,
      ST_SQ_WAIT,
      ST_WSS_GO,
      ST_WSS_WAIT,
      ST_D_GO,
      ST_D_WAIT,
      ST_V_CHECK,
      ST_V_GO,
      ST_V_WAIT,
      ST_RESP
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_RESET,
      OP_ELAP,
      OP_COMMIT,
      OP_END,
      OP_FIRST,
      OP_ADD_WS,
      OP_SET_SQ,
      OP_ADD_WSS,
      OP_STATS,
      OP_VAR,
      OP_LOAD_RSP
   } dp_op_type;

   typedef enum logic [2:0] {
      MUL_HELD_ELAP,
      MUL_HELD_HELD,
      MUL_SQ_ELAP,
      MUL_QUOT_LEN,
      MUL_MEAN_MEAN
   } mul_sel_type;

   typedef enum logic {
      DIV_END,
      DIV_STATS
   } div_sel_type;

   typedef struct packed {
      logic        capture;
      dp_op_type   op;
      logic        mul_start;
      mul_sel_type mul_sel;
      logic        div_start;
      div_sel_type div_sel;
   } dp_cmd_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic              mul_done;
      logic              div_done;
      logic              elap_zero;
      logic              span_zero;
      logic              mean_wide;
      logic              rsp_busy;
   } dp_stat_type;

endpackage

// ===== rtl/time_weighted_stats_accumulator_unit.sv =====
// ----------------------------------------------------------------------------
// time_weighted_stats_accumulator_unit
// Time-weighted mean, variance, high/low marks and sample count of a level
// signal over one statistics period.
// ----------------------------------------------------------------------------
// One item is worked on at a time; req_tready is high only while the
// block is idle. A sample runs three multiplies, each over four 16-bit
// digit steps. A query runs a divide for the aligned period end and a
// multiply. When time passed since the last update, it adds three more
// multiplies and may add a second divide for mean and mean square on the
// same divider and a last multiply for the variance. A query result sits
// in an output register, so the next item is taken while it waits for
// rsp_tready; a later query holds in its response state until that
// register is free. The period length is written through csr_we and
// csr_wdata; the user must write it only while the block is idle, which
// the block itself does not enforce. Zero acts as one.
module time_weighted_stats_accumulator_unit #(
   parameter int TIME_BITS = twsa_pkg::DEF_TIME_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [twsa_pkg::LEN_W-1:0]      csr_wdata,   // period_length_ms
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // time_ms, sample_value, start_ms, carry_over, zero pad
   input  logic [((2*TIME_BITS+twsa_pkg::VAL_W+1+7)/8)*8-1:0] req_tdata,
   input  logic [twsa_pkg::MODE_W-1:0]     req_tuser,   // mode
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // mean, variance, high_mark, low_mark, sample_count
   output logic [twsa_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   twsa_pkg::dp_cmd_type  cmd;
   twsa_pkg::dp_stat_type stat;

   twsa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   twsa_dp #(
      .TIME_BITS (TIME_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .stat       (stat)
   );

endmodule

// ===== rtl/twsa_mul.sv =====
// ----------------------------------------------------------------------------
// twsa_mul
// Iterative multiplier, product modulo 2^64, one 16-bit digit per cycle.
// ----------------------------------------------------------------------------
module twsa_mul (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [twsa_pkg::ACC_W-1:0] op_a,
   input  logic [twsa_pkg::ACC_W-1:0] op_b,
   output logic                       done,
   output logic [twsa_pkg::ACC_W-1:0] product
);

   localparam int AW = twsa_pkg::ACC_W;
   localparam int DW = twsa_pkg::MUL_DIGIT_W;
   localparam int CW = twsa_pkg::MUL_CNT_W;

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [AW-1:0] a_ff, a_in;
   logic [AW-1:0] b_ff, b_in;
   logic [AW-1:0] acc_ff, acc_in;
   logic [AW+DW-1:0] partial;
   logic          last;

   always_comb begin
      partial = a_ff * b_ff[DW-1:0];
      last    = (cnt_ff == CW'(twsa_pkg::MUL_STEPS - 1));
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      done_in = busy_ff && last;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         a_in    = op_a;
         b_in    = op_b;
         acc_in  = '0;
      end else if (busy_ff) begin
         acc_in = acc_ff + partial[AW-1:0];
         a_in   = a_ff << DW;
         b_in   = b_ff >> DW;
         cnt_in = cnt_ff + CW'(1);
         if (last) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

// ===== rtl/twsa_div.sv =====
// ----------------------------------------------------------------------------
// twsa_div
// Restoring divider, one quotient bit per cycle, two dividends over one
// shared divisor.
// ----------------------------------------------------------------------------
module twsa_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [twsa_pkg::ACC_W-1:0] num0,
   input  logic [twsa_pkg::ACC_W-1:0] num1,
   input  logic [twsa_pkg::ACC_W-1:0] den,
   output logic                       done,
   output logic [twsa_pkg::ACC_W-1:0] quot0,
   output logic [twsa_pkg::ACC_W-1:0] quot1
);

   localparam int AW = twsa_pkg::ACC_W;
   localparam int CW = twsa_pkg::DIV_CNT_W;

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [AW-1:0] den_ff, den_in;
   logic [AW-1:0] rem_ff [2];
   logic [AW-1:0] rem_in [2];
   logic [AW-1:0] q_ff [2];
   logic [AW-1:0] q_in [2];
   logic [AW:0]   trial [2];
   logic [AW:0]   diff [2];
   logic          last;

   always_comb begin
      last    = (cnt_ff == CW'(AW - 1));
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      den_in  = den_ff;
      done_in = busy_ff && last;
      for (int i = 0; i < 2; i++) begin
         trial[i]  = {rem_ff[i], q_ff[i][AW-1]};
         diff[i]   = trial[i] - {1'b0, den_ff};
         rem_in[i] = rem_ff[i];
         q_in[i]   = q_ff[i];
      end
      if (start) begin
         busy_in   = 1'b1;
         cnt_in    = '0;
         den_in    = den;
         rem_in[0] = '0;
         rem_in[1] = '0;
         q_in[0]   = num0;
         q_in[1]   = num1;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + CW'(1);
         for (int i = 0; i < 2; i++) begin
            if (!diff[i][AW]) begin
               rem_in[i] = diff[i][AW-1:0];
               q_in[i]   = {q_ff[i][AW-2:0], 1'b1};
            end else begin
               rem_in[i] = trial[i][AW-1:0];
               q_in[i]   = {q_ff[i][AW-2:0], 1'b0};
            end
         end
         if (last) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      den_ff <= den_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
   end

   assign done  = done_ff;
   assign quot0 = q_ff[0];
   assign quot1 = q_ff[1];

endmodule

// ===== rtl/twsa_ctrl.sv =====
// ----------------------------------------------------------------------------
// twsa_ctrl
// Sequencer for reset, sample and query items of the statistics accumulator.
// ----------------------------------------------------------------------------
module twsa_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output twsa_pkg::dp_cmd_type  cmd,
   input  twsa_pkg::dp_stat_type stat
);

   twsa_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         twsa_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = twsa_pkg::ST_DECODE;
            end
         end
         twsa_pkg::ST_DECODE: begin
            priority if (stat.mode == twsa_pkg::MODE_RESET) begin
               state_in = twsa_pkg::ST_RESET;
            end else if (stat.mode == twsa_pkg::MODE_SAMPLE) begin
               state_in = twsa_pkg::ST_S_ELAP;
            end else if (stat.mode == twsa_pkg::MODE_QUERY) begin
               state_in = twsa_pkg::ST_Q_DIV_GO;
            end else begin
               state_in = twsa_pkg::ST_IDLE;
            end
         end
         twsa_pkg::ST_RESET:    state_in = twsa_pkg::ST_IDLE;
         twsa_pkg::ST_S_ELAP:   state_in = twsa_pkg::ST_WS_GO;
         twsa_pkg::ST_S_COMMIT: state_in = twsa_pkg::ST_IDLE;
         twsa_pkg::ST_Q_DIV_GO: state_in = twsa_pkg::ST_Q_DIV_WAIT;
         twsa_pkg::ST_Q_DIV_WAIT: begin
            if (stat.div_done) begin
               state_in = twsa_pkg::ST_Q_MUL_GO;
            end
         end
         twsa_pkg::ST_Q_MUL_GO: state_in = twsa_pkg::ST_Q_MUL_WAIT;
         twsa_pkg::ST_Q_MUL_WAIT: begin
            if (stat.mul_done) begin
               state_in = twsa_pkg::ST_Q_FIRST;
            end
         end
         twsa_pkg::ST_Q_FIRST: state_in = twsa_pkg::ST_Q_CHECK;
         twsa_pkg::ST_Q_CHECK: begin
            state_in = stat.elap_zero ? twsa_pkg::ST_RESP : twsa_pkg::ST_WS_GO;
         end
         twsa_pkg::ST_WS_GO: state_in = twsa_pkg::ST_WS_WAIT;
         twsa_pkg::ST_WS_WAIT: begin
            if (stat.mul_done) begin
               state_in = twsa_pkg::ST_SQ_GO;
            end
         end
         twsa_pkg::ST_SQ_GO: state_in = twsa_pkg::ST_SQ_WAIT;
         twsa_pkg::ST_SQ_WAIT: begin
            if (stat.mul_done) begin
               state_in = twsa_pkg::ST_WSS_GO;
            end
         end
         twsa_pkg::ST_WSS_GO: state_in = twsa_pkg::ST_WSS_WAIT;
         twsa_pkg::ST_WSS_WAIT: begin
            if (stat.mul_done) begin
               priority if (stat.mode == twsa_pkg::MODE_SAMPLE) begin
                  state_in = twsa_pkg::ST_S_COMMIT;
               end else if (stat.span_zero) begin
                  state_in = twsa_pkg::ST_RESP;
               end else begin
                  state_in = twsa_pkg::ST_D_GO;
               end
            end
         end
         twsa_pkg::ST_D_GO: state_in = twsa_pkg::ST_D_WAIT;
         twsa_pkg::ST_D_WAIT: begin
            if (stat.div_done) begin
               state_in = twsa_pkg::ST_V_CHECK;
            end
         end
         twsa_pkg::ST_V_CHECK: begin
            state_in = stat.mean_wide ? twsa_pkg::ST_RESP : twsa_pkg::ST_V_GO;
         end
         twsa_pkg::ST_V_GO: state_in = twsa_pkg::ST_V_WAIT;
         twsa_pkg::ST_V_WAIT: begin
            if (stat.mul_done) begin
               state_in = twsa_pkg::ST_RESP;
            end
         end
         twsa_pkg::ST_RESP: begin
            if (!stat.rsp_busy) begin
               state_in = twsa_pkg::ST_IDLE;
            end
         end
         default: state_in = twsa_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready    = (state_ff == twsa_pkg::ST_IDLE);
      cmd.capture   = 1'b0;
      cmd.op        = twsa_pkg::OP_NONE;
      cmd.mul_start = 1'b0;
      cmd.mul_sel   = twsa_pkg::MUL_HELD_ELAP;
      cmd.div_start = 1'b0;
      cmd.div_sel   = twsa_pkg::DIV_END;
      unique case (state_ff)
         twsa_pkg::ST_IDLE:     cmd.capture = req_tvalid;
         twsa_pkg::ST_RESET:    cmd.op = twsa_pkg::OP_RESET;
         twsa_pkg::ST_S_ELAP:   cmd.op = twsa_pkg::OP_ELAP;
         twsa_pkg::ST_S_COMMIT: cmd.op = twsa_pkg::OP_COMMIT;
         twsa_pkg::ST_Q_DIV_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = twsa_pkg::DIV_END;
         end
         twsa_pkg::ST_Q_MUL_GO: begin
            cmd.mul_start = 1'b1;
            cmd.mul_sel   = twsa_pkg::MUL_QUOT_LEN;
         end
         twsa_pkg::ST_Q_MUL_WAIT: begin
            if (stat.mul_done) begin
               cmd.op = twsa_pkg::OP_END;
            end
         end
         twsa_pkg::ST_Q_FIRST: cmd.op = twsa_pkg::OP_FIRST;
         twsa_pkg::ST_WS_GO: begin
            cmd.mul_start = 1'b1;
            cmd.mul_sel   = twsa_pkg::MUL_HELD_ELAP;
         end
         twsa_pkg::ST_WS_WAIT: begin
            if (stat.mul_done) begin
               cmd.op = twsa_pkg::OP_ADD_WS;
            end
         end
         twsa_pkg::ST_SQ_GO: begin
            cmd.mul_start = 1'b1;
            cmd.mul_sel   = twsa_pkg::MUL_HELD_HELD;
         end
         twsa_pkg::ST_SQ_WAIT: begin
            if (stat.mul_done) begin
               cmd.op = twsa_pkg::OP_SET_SQ;
            end
         end
         twsa_pkg::ST_WSS_GO: begin
            cmd.mul_start = 1'b1;
            cmd.mul_sel   = twsa_pkg::MUL_SQ_ELAP;
         end
         twsa_pkg::ST_WSS_WAIT: begin
            if (stat.mul_done) begin
               cmd.op = twsa_pkg::OP_ADD_WSS;
            end
         end
         twsa_pkg::ST_D_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = twsa_pkg::DIV_STATS;
         end
         twsa_pkg::ST_D_WAIT: begin
            if (stat.div_done) begin
               cmd.op = twsa_pkg::OP_STATS;
            end
         end
         twsa_pkg::ST_V_GO: begin
            cmd.mul_start = 1'b1;
            cmd.mul_sel   = twsa_pkg::MUL_MEAN_MEAN;
         end
         twsa_pkg::ST_V_WAIT: begin
            if (stat.mul_done) begin
               cmd.op = twsa_pkg::OP_VAR;
            end
         end
         twsa_pkg::ST_RESP: begin
            if (!stat.rsp_busy) begin
               cmd.op = twsa_pkg::OP_LOAD_RSP;
            end
         end
         default: begin
            cmd.op = twsa_pkg::OP_NONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= twsa_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/twsa_dp.sv =====
// ----------------------------------------------------------------------------
// twsa_dp
// Datapath: statistics state, item capture, shared multiplier and divider,
// response register.
// ----------------------------------------------------------------------------
module twsa_dp #(
   parameter int TIME_BITS = twsa_pkg::DEF_TIME_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [twsa_pkg::LEN_W-1:0]      csr_wdata,
   input  logic [((2*TIME_BITS+twsa_pkg::VAL_W+1+7)/8)*8-1:0] req_tdata,
   input  logic [twsa_pkg::MODE_W-1:0]     req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [twsa_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  twsa_pkg::dp_cmd_type            cmd,
   output twsa_pkg::dp_stat_type           stat
);

   localparam int AW       = twsa_pkg::ACC_W;
   localparam int VW       = twsa_pkg::VAL_W;
   localparam int NW       = twsa_pkg::CNT_W;
   localparam int LW       = twsa_pkg::LEN_W;
   localparam int TW       = TIME_BITS;
   localparam int SMP_LO   = TW;
   localparam int START_LO = TW + VW;
   localparam int CARRY_B  = 2 * TW + VW;

   // captured item
   logic [twsa_pkg::MODE_W-1:0] mode_ff, mode_in;
   logic [TW-1:0]               now_ff, now_in;
   logic [VW-1:0]               sample_ff, sample_in;
   logic [TW-1:0]               start_ff, start_in;
   logic                        carry_ff, carry_in;

   // statistics state
   logic [LW-1:0] len_ff, len_in;
   logic [VW-1:0] held_ff, held_in;
   logic [TW-1:0] lut_ff, lut_in;
   logic [TW-1:0] pst_ff, pst_in;
   logic [NW-1:0] cnt_ff, cnt_in;
   logic [AW-1:0] ws_ff, ws_in;
   logic [AW-1:0] wss_ff, wss_in;
   logic [VW-1:0] peak_ff, peak_in;
   logic [VW-1:0] trough_ff, trough_in;

   // work registers
   logic [TW-1:0] elap_ff, elap_in;
   logic [TW-1:0] span_ff, span_in;
   logic [AW-1:0] end_ff, end_in;
   logic [AW-1:0] sq_ff, sq_in;
   logic [AW-1:0] mean_ff, mean_in;
   logic [AW-1:0] qsq_ff, qsq_in;
   logic [AW-1:0] var_ff, var_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [twsa_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [LW-1:0] len_eff;
   logic [AW-1:0] first;
   logic [TW-1:0] first_t;
   logic [TW-1:0] start_eff;
   logic [VW-1:0] held_rst;

   logic [AW-1:0] mul_a, mul_b, mul_prod;
   logic          mul_done;
   logic [AW-1:0] div_n0, div_n1, div_d, quot0, quot1;
   logic          div_done;

   twsa_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .done    (mul_done),
      .product (mul_prod)
   );

   twsa_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num0  (div_n0),
      .num1  (div_n1),
      .den   (div_d),
      .done  (div_done),
      .quot0 (quot0),
      .quot1 (quot1)
   );

   always_comb begin
      len_eff   = (len_ff == '0) ? LW'(1) : len_ff;
      first     = (end_ff < AW'(now_ff)) ? end_ff : AW'(now_ff);
      first_t   = first[TW-1:0];
      start_eff = (start_ff == '0) ? now_ff : start_ff;
      held_rst  = carry_ff ? held_ff : '0;
   end

   always_comb begin
      unique case (cmd.mul_sel)
         twsa_pkg::MUL_HELD_ELAP: begin
            mul_a = AW'(held_ff);
            mul_b = AW'(elap_ff);
         end
         twsa_pkg::MUL_HELD_HELD: begin
            mul_a = AW'(held_ff);
            mul_b = AW'(held_ff);
         end
         twsa_pkg::MUL_SQ_ELAP: begin
            mul_a = sq_ff;
            mul_b = AW'(elap_ff);
         end
         twsa_pkg::MUL_QUOT_LEN: begin
            mul_a = quot0;
            mul_b = AW'(len_eff);
         end
         twsa_pkg::MUL_MEAN_MEAN: begin
            mul_a = mean_ff;
            mul_b = mean_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      unique case (cmd.div_sel)
         twsa_pkg::DIV_END: begin
            div_n0 = AW'(pst_ff) + AW'(len_eff);
            div_n1 = '0;
            div_d  = AW'(len_eff);
         end
         twsa_pkg::DIV_STATS: begin
            div_n0 = ws_ff;
            div_n1 = wss_ff;
            div_d  = AW'(span_ff);
         end
         default: begin
            div_n0 = '0;
            div_n1 = '0;
            div_d  = '0;
         end
      endcase
   end

   always_comb begin
      mode_in      = mode_ff;
      now_in       = now_ff;
      sample_in    = sample_ff;
      start_in     = start_ff;
      carry_in     = carry_ff;
      len_in       = len_ff;
      held_in      = held_ff;
      lut_in       = lut_ff;
      pst_in       = pst_ff;
      cnt_in       = cnt_ff;
      ws_in        = ws_ff;
      wss_in       = wss_ff;
      peak_in      = peak_ff;
      trough_in    = trough_ff;
      elap_in      = elap_ff;
      span_in      = span_ff;
      end_in       = end_ff;
      sq_in        = sq_ff;
      mean_in      = mean_ff;
      qsq_in       = qsq_ff;
      var_in       = var_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      if (cmd.capture) begin
         mode_in   = req_tuser;
         now_in    = req_tdata[TW-1:0];
         sample_in = req_tdata[SMP_LO +: VW];
         start_in  = req_tdata[START_LO +: TW];
         carry_in  = req_tdata[CARRY_B];
      end

      if (csr_we) begin
         len_in = csr_wdata;
      end

      unique case (cmd.op)
         twsa_pkg::OP_RESET: begin
            cnt_in    = '0;
            ws_in     = '0;
            wss_in    = '0;
            held_in   = held_rst;
            peak_in   = held_rst;
            trough_in = held_rst;
            lut_in    = start_eff;
            pst_in    = start_eff;
         end
         twsa_pkg::OP_ELAP: begin
            elap_in = now_ff - lut_ff;
         end
         twsa_pkg::OP_COMMIT: begin
            lut_in  = now_ff;
            held_in = sample_ff;
            cnt_in  = cnt_ff + NW'(1);
            if (sample_ff < trough_ff) begin
               trough_in = sample_ff;
            end
            if (sample_ff > peak_ff) begin
               peak_in = sample_ff;
            end
         end
         twsa_pkg::OP_END: begin
            end_in = mul_prod;
         end
         twsa_pkg::OP_FIRST: begin
            elap_in = first_t - lut_ff;
            span_in = first_t - pst_ff;
            lut_in  = first_t;
            mean_in = AW'(held_ff);
            var_in  = '0;
         end
         twsa_pkg::OP_ADD_WS: begin
            ws_in = ws_ff + mul_prod;
         end
         twsa_pkg::OP_SET_SQ: begin
            sq_in = mul_prod;
         end
         twsa_pkg::OP_ADD_WSS: begin
            wss_in = wss_ff + mul_prod;
         end
         twsa_pkg::OP_STATS: begin
            mean_in = quot0;
            qsq_in  = quot1;
         end
         twsa_pkg::OP_VAR: begin
            var_in = (qsq_ff > mul_prod) ? (qsq_ff - mul_prod) : '0;
         end
         twsa_pkg::OP_LOAD_RSP: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = {cnt_ff, trough_ff, peak_ff, var_ff, mean_ff};
         end
         default: begin
            rsp_data_in = rsp_data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= twsa_pkg::DEF_PERIOD_LEN;
         held_ff      <= '0;
         lut_ff       <= '0;
         pst_ff       <= '0;
         cnt_ff       <= '0;
         ws_ff        <= '0;
         wss_ff       <= '0;
         peak_ff      <= '0;
         trough_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         held_ff      <= held_in;
         lut_ff       <= lut_in;
         pst_ff       <= pst_in;
         cnt_ff       <= cnt_in;
         ws_ff        <= ws_in;
         wss_ff       <= wss_in;
         peak_ff      <= peak_in;
         trough_ff    <= trough_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      now_ff      <= now_in;
      sample_ff   <= sample_in;
      start_ff    <= start_in;
      carry_ff    <= carry_in;
      elap_ff     <= elap_in;
      span_ff     <= span_in;
      end_ff      <= end_in;
      sq_ff       <= sq_in;
      mean_ff     <= mean_in;
      qsq_ff      <= qsq_in;
      var_ff      <= var_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      stat.mode      = mode_ff;
      stat.mul_done  = mul_done;
      stat.div_done  = div_done;
      stat.elap_zero = (elap_ff == '0);
      stat.span_zero = (span_ff == '0);
      stat.mean_wide = (mean_ff[AW-1:VW] != '0);
      stat.rsp_busy  = rsp_valid_ff && !rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== rtl/twsa_checker.sv =====
// ----------------------------------------------------------------------------
// twsa_checker
// Port-level checks of the statistics accumulator, bound to the top level.
// ----------------------------------------------------------------------------
module twsa_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [twsa_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   localparam int AW = twsa_pkg::ACC_W;
   localparam int VW = twsa_pkg::VAL_W;

   logic [AW-1:0] mean;
   logic [AW-1:0] variance;
   logic [VW-1:0] high_mark;
   logic [VW-1:0] low_mark;

   assign mean      = rsp_tdata[twsa_pkg::RSP_MEAN_LO +: AW];
   assign variance  = rsp_tdata[twsa_pkg::RSP_VAR_LO +: AW];
   assign high_mark = rsp_tdata[twsa_pkg::RSP_HIGH_LO +: VW];
   assign low_mark  = rsp_tdata[twsa_pkg::RSP_LOW_LO +: VW];

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tready))
      else $error("result appeared without a query in progress");

   a_marks_order: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> low_mark <= high_mark)
      else $error("low mark above high mark");

   a_wide_mean_var: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (mean[AW-1:VW] != '0) |-> variance == '0)
      else $error("variance set with mean beyond 32 bits");

endmodule

bind time_weighted_stats_accumulator_unit twsa_checker u_twsa_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
